[hdl/pcm_sample_decode_frame_amplitude_defines.svh]
// assertion macros for the pcm frame amplitude block
// no dependencies; included by the files that carry assertions
`ifndef PCM_SAMPLE_DECODE_FRAME_AMPLITUDE_DEFINES_SVH
`define PCM_SAMPLE_DECODE_FRAME_AMPLITUDE_DEFINES_SVH
`ifndef ASSERT_OFF
// property checked while out of reset
`define PCMAMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked at every edge, reset included
`define PCMAMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PCMAMP_ASSERT(label, prop, msg)
`define PCMAMP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[hdl/pcmamp_pkg.sv]
// shared types and constants of the pcm frame amplitude block
// no dependencies; imported by pcm_sample_decode_frame_amplitude
package pcmamp_pkg;

  // field and state widths
  localparam int SAMPLE_W      = 32;
  localparam int BYTES_W       = 3;
  localparam int CNT_W         = 16;
  localparam int SUM_W         = 48;
  localparam int AVG_W         = 40;
  localparam int FRACTION_BITS = 8;

  // divider: dividend is the sum with the fraction bits appended
  localparam int DIV_W  = SUM_W + FRACTION_BITS;
  localparam int STEP_W = $clog2(DIV_W);

  // configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // register reset values
  localparam logic [BYTES_W-1:0] SAMPLE_BYTES_RST = BYTES_W'(2);
  localparam logic [CNT_W-1:0]   SPF_RST          = CNT_W'(256);

  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_BYTES      = 1'b0,
    CFG_SAMPLES_PER_FRAME = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

[hdl/pcm_sample_decode_frame_amplitude.sv]
// pcm sample decoder with per-frame mean absolute amplitude
// depends on pcmamp_pkg and pcm_sample_decode_frame_amplitude_defines.svh
//
// Usage: each input request carries one little-endian pcm word and a last
// flag. The block sign-extends the low sample_bytes bytes and returns one
// result request per input: the decoded sample, and when the sample closes
// a frame (frame length reached or last flag set) the frame mean of the
// absolute samples with 8 fraction bits, truncated.
// Flow: a sample that does not close a frame passes S_PREP and S_DONE
// on its way to the output register; a sample that closes a frame also
// passes S_DIV, where the single restoring divider produces one quotient
// bit per cycle over the 56-bit dividend. The next request is taken once
// the block is back in S_IDLE. One request is in work at a time; in_stall
// is high from accept until the result moves to the output register,
// which holds it while out_stall is high.
// Reset: configuration returns to 2 bytes and 256 samples per frame, the
// running sum and count clear, no result is pending.
// Configuration is to be written through cfg_wr_en / cfg_index / cfg_wdata
// only while the block is idle; the block itself does not enforce this.
`include "pcm_sample_decode_frame_amplitude_defines.svh"
module pcm_sample_decode_frame_amplitude
  import pcmamp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SAMPLE_W-1:0]          in_sample_word,
  input  logic                         in_last_sample,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]   out_sample_value,
  output logic                         out_amp_valid,
  output logic [AVG_W-1:0]             out_avg_amplitude
);

  // configuration registers
  logic [BYTES_W-1:0] sample_bytes_r;
  logic [CNT_W-1:0]   spf_r;

  // sequencer
  state_t state_r, state_nxt;
  logic   in_take;
  logic   out_free;

  // request capture
  logic [SAMPLE_W-1:0] word_r, word_nxt;
  logic                last_r, last_nxt;

  // frame state
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // working result
  logic [SAMPLE_W-1:0] value_r, value_nxt;
  logic                amp_r, amp_nxt;

  // divider
  logic [DIV_W-1:0]  dq_r, dq_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  divisor_r, divisor_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              div_last;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_value_nxt;
  logic                out_amp_r, out_amp_nxt;
  logic [AVG_W-1:0]    out_avg_r, out_avg_nxt;

  // decode and accumulate signals
  logic [SAMPLE_W-1:0] dec_value;
  logic [SAMPLE_W:0]   dec_mag;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    count_inc;
  logic [CNT_W-1:0]    spf_eff;
  logic                flush;
  logic                close_frame;

  // divider step signals
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_sub;
  logic               q_bit;
  logic [AVG_W-1:0]   avg_sat;
  logic [DIV_W-1:0]   dq_hi;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign div_last = (step_r == STEP_W'(DIV_W - 1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_bytes_r <= SAMPLE_BYTES_RST;
      spf_r          <= SPF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SAMPLE_BYTES:      sample_bytes_r <= cfg_wdata[BYTES_W-1:0];
        CFG_SAMPLES_PER_FRAME: spf_r          <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sign extension at the configured byte count, out-of-range counts clamped
  always_comb begin
    unique case (sample_bytes_r) inside
      3'd0, 3'd1: dec_value = {{24{word_r[7]}},  word_r[7:0]};
      3'd2:       dec_value = {{16{word_r[15]}}, word_r[15:0]};
      3'd3:       dec_value = {{8{word_r[23]}},  word_r[23:0]};
      default:    dec_value = word_r;
    endcase
  end

  // magnitude, one bit wider for the most negative sample
  assign dec_mag = dec_value[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {1'b1, dec_value})
                                         : {1'b0, dec_value};

  // running sum and frame close decision
  assign sum_new     = sum_r + SUM_W'(dec_mag);
  assign count_inc   = count_r + CNT_W'(1);
  assign spf_eff     = (spf_r == '0) ? CNT_W'(1) : spf_r;
  assign flush       = (count_inc >= spf_eff) || last_r;
  assign close_frame = flush && (count_inc != '0);

  // one restoring divider step
  assign rem_sh  = {rem_r, dq_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_r};
  assign q_bit   = (rem_sh >= {1'b0, divisor_r});

  // quotient saturation
  assign dq_hi   = dq_r >> AVG_W;
  assign avg_sat = (dq_hi != '0) ? AVG_MAX : dq_r[AVG_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_take) state_nxt = S_PREP;
      S_PREP: state_nxt = close_frame ? S_DIV : S_DONE;
      S_DIV:  if (div_last) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    word_nxt      = word_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    value_nxt     = value_r;
    amp_nxt       = amp_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    divisor_nxt   = divisor_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_amp_nxt   = out_amp_r;
    out_avg_nxt   = out_avg_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          word_nxt = in_sample_word;
          last_nxt = in_last_sample;
        end
      end
      S_PREP: begin
        value_nxt = dec_value;
        amp_nxt   = close_frame;
        step_nxt  = '0;
        rem_nxt   = '0;
        if (close_frame) begin
          dq_nxt      = DIV_W'({sum_new, {FRACTION_BITS{1'b0}}});
          divisor_nxt = count_inc;
          sum_nxt     = '0;
          count_nxt   = '0;
        end else begin
          sum_nxt   = sum_new;
          count_nxt = count_inc;
        end
      end
      S_DIV: begin
        dq_nxt   = {dq_r[DIV_W-2:0], q_bit};
        rem_nxt  = q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        step_nxt = step_r + STEP_W'(1);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = value_r;
          out_amp_nxt   = amp_r;
          out_avg_nxt   = amp_r ? avg_sat : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    last_r      <= last_nxt;
    value_r     <= value_nxt;
    amp_r       <= amp_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    divisor_r   <= divisor_nxt;
    out_value_r <= out_value_nxt;
    out_amp_r   <= out_amp_nxt;
    out_avg_r   <= out_avg_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_sample_value  = signed'(out_value_r);
  assign out_amp_valid     = out_amp_r;
  assign out_avg_amplitude = out_avg_r;

  // checks
  `PCMAMP_ASSERT(a_accept_to_prep, in_take |=> state_r == S_PREP, "accept did not start decode")
  `PCMAMP_ASSERT(a_div_nonzero, state_r == S_DIV |-> divisor_r != '0, "divide by zero count")
  `PCMAMP_ASSERT(a_rem_bound, state_r == S_DIV |-> rem_r < divisor_r, "remainder out of range")
  `PCMAMP_ASSERT(a_div_start, state_r != S_DIV ##1 state_r == S_DIV |-> step_r == '0, "divider step not cleared")
  `PCMAMP_ASSERT(a_avg_zero, out_valid_r && !out_amp_r |-> out_avg_r == '0, "mean set without frame close")

endmodule

[verif/pcm_amplitude_checker.sv]
// checker for the pcm frame amplitude block: watches the config, input and result ports
// depends on pcmamp_pkg; instantiated by tb_pcm_sample_decode_frame_amplitude
`timescale 1ns / 1ps
module pcm_amplitude_checker
  import pcmamp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [SAMPLE_W-1:0]        in_sample_word,
  input  logic                       in_last_sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sample_value,
  input  logic                       out_amp_valid,
  input  logic [AVG_W-1:0]           out_avg_amplitude,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       amp_valid;
    logic [AVG_W-1:0]           avg;
  } sample_result_t;

  // shadow of the block's registers and frame accumulator
  logic [BYTES_W-1:0] bytes_cfg;
  logic [CNT_W-1:0]   frame_len_cfg;
  logic [SUM_W-1:0]   abs_total;
  logic [CNT_W-1:0]   frame_fill;
  sample_result_t     awaited_q[$];

  // mean with fraction bits, truncated, saturated at the output width
  function automatic logic [AVG_W-1:0] frame_mean(input logic [SUM_W-1:0] total,
                                                  input logic [CNT_W-1:0] n);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] m;
    q = 64'(total) / 64'(n);
    r = 64'(total) % 64'(n);
    if (q > (64'(AVG_MAX) >> FRACTION_BITS)) return AVG_MAX;
    m = (q << FRACTION_BITS) + ((r << FRACTION_BITS) / 64'(n));
    if (m > 64'(AVG_MAX)) return AVG_MAX;
    return m[AVG_W-1:0];
  endfunction

  // decode one sample, fold it into the frame, close the frame if due
  function automatic sample_result_t decode_and_average(input logic [SAMPLE_W-1:0] word,
                                                        input logic last);
    sample_result_t res;
    int             nbytes;
    logic [63:0]    span;
    logic [63:0]    raw;
    logic [63:0]    mag;
    logic [CNT_W-1:0] len;
    // out of range byte counts clamp to 1..4
    if (bytes_cfg == 0) nbytes = 1;
    else if (bytes_cfg > 4) nbytes = 4;
    else nbytes = int'(bytes_cfg);
    span = (64'd1 << (nbytes * 8)) - 64'd1;
    raw  = {32'd0, word} & span;
    if (raw[nbytes*8-1]) begin
      mag       = span + 64'd1 - raw;
      res.value = SAMPLE_W'(raw | ~span);
    end else begin
      mag       = raw;
      res.value = SAMPLE_W'(raw);
    end
    abs_total  = abs_total + SUM_W'(mag);
    frame_fill = frame_fill + CNT_W'(1);
    // zero frame length behaves as one
    len = (frame_len_cfg == '0) ? CNT_W'(1) : frame_len_cfg;
    res.amp_valid = 1'b0;
    res.avg       = '0;
    if ((frame_fill >= len || last) && frame_fill != '0) begin
      res.amp_valid = 1'b1;
      res.avg       = frame_mean(abs_total, frame_fill);
      abs_total     = '0;
      frame_fill    = '0;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] seen,
                               input logic [63:0] wanted);
    if (mismatches < 40)
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, seen, wanted);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    sample_result_t want;
    if (!rst_n) begin
      bytes_cfg     = SAMPLE_BYTES_RST;
      frame_len_cfg = SPF_RST;
      abs_total     = '0;
      frame_fill    = '0;
      mismatches    = 0;
      awaited_q.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        if (cfg_index == CFG_SAMPLE_BYTES) bytes_cfg = cfg_wdata[BYTES_W-1:0];
        else if (cfg_index == CFG_SAMPLES_PER_FRAME) frame_len_cfg = cfg_wdata[CNT_W-1:0];
      end
      // result side: compare against the oldest expectation
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          flag_mismatch("unexpected result", 64'(out_sample_value), 64'd0);
        end else begin
          want = awaited_q.pop_front();
          if (out_sample_value !== want.value)
            flag_mismatch("sample_value", 64'(out_sample_value), 64'(want.value));
          if (out_amp_valid !== want.amp_valid)
            flag_mismatch("amp_valid", 64'(out_amp_valid), 64'(want.amp_valid));
          if (out_avg_amplitude !== want.avg)
            flag_mismatch("avg_amplitude", 64'(out_avg_amplitude), 64'(want.avg));
        end
      end
      // input side: predict the result of each accepted request
      if (in_valid && !in_stall)
        awaited_q.push_back(decode_and_average(in_sample_word, in_last_sample));
    end
    outstanding = awaited_q.size();
  end

endmodule

[verif/tb_pcm_sample_decode_frame_amplitude.sv]
// top of the pcm frame amplitude testbench: clock, reset, stimulus and verdict
// depends on pcmamp_pkg, pcm_sample_decode_frame_amplitude and pcm_amplitude_checker
`timescale 1ns / 1ps
module tb_pcm_sample_decode_frame_amplitude;
  import pcmamp_pkg::*;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic [SAMPLE_W-1:0]        in_sample_word;
  logic                       in_last_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample_value;
  logic                       out_amp_valid;
  logic [AVG_W-1:0]           out_avg_amplitude;
  int                         fail_count;
  int                         pending;
  bit                         calm;
  int                         eff_bytes;

  pcm_sample_decode_frame_amplitude u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_word    (in_sample_word),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_value  (out_sample_value),
    .out_amp_valid     (out_amp_valid),
    .out_avg_amplitude (out_avg_amplitude)
  );

  pcm_amplitude_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_word    (in_sample_word),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_value  (out_sample_value),
    .out_amp_valid     (out_amp_valid),
    .out_avg_amplitude (out_avg_amplitude),
    .mismatches        (fail_count),
    .outstanding       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #1_600_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off to back the block up
  initial begin : result_sink
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (!rst_n) begin
        out_stall <= 1'b0;
      end else if (!held && taken >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one request and hold it until accepted
  task automatic send_sample(input logic [SAMPLE_W-1:0] word, input logic last);
    in_valid       <= 1'b1;
    in_sample_word <= word;
    in_last_sample <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // random gap on the request side
  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // wait until every result is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // register write for the byte count, tracking the clamped width
  task automatic set_bytes(input logic [CFG_DATA_W-1:0] data);
    logic [BYTES_W-1:0] raw;
    raw = data[BYTES_W-1:0];
    if (raw == 0) eff_bytes = 1;
    else if (raw > 4) eff_bytes = 4;
    else eff_bytes = int'(raw);
    write_reg(CFG_SAMPLE_BYTES, data);
  endtask

  // random word, sometimes pinned to an extreme of the current width
  function automatic logic [SAMPLE_W-1:0] pick_word(input int nb);
    logic [63:0] span;
    logic [63:0] w;
    logic [63:0] pat;
    span = (64'd1 << (nb * 8)) - 64'd1;
    w    = 64'($urandom);
    case ($urandom_range(0, 9))
      0: pat = 64'd1 << (nb * 8 - 1);
      1: pat = span >> 1;
      2: pat = 64'd0;
      3: pat = span;
      default: pat = w;
    endcase
    return SAMPLE_W'((w & ~span) | (pat & span));
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] data;
    int                    pick;
    calm           = 1'b0;
    eff_bytes      = 2;
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_SAMPLE_BYTES;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_sample_word <= '0;
    in_last_sample <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 16-bit samples, partial frame flushed by last
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'hFFFF_8000, 1'b0);
    send_sample(32'h1234_0001, 1'b1);
    settle();

    // 8-bit signed samples, zero frame length closes every sample
    set_bytes(16'hFFF9);
    write_reg(CFG_SAMPLES_PER_FRAME, 16'h0000);
    send_sample(32'h0000_0080, 1'b0);
    send_sample(32'h0000_007F, 1'b0);
    send_sample(32'hFFFF_FF00, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    settle();

    // zero byte count behaves as one byte
    set_bytes(16'h0008);
    write_reg(CFG_SAMPLES_PER_FRAME, 16'd3);
    send_sample(32'h0000_00FF, 1'b0);
    send_sample(32'h0000_0080, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    settle();

    // 24-bit extremes with a last flag
    set_bytes(16'd3);
    write_reg(CFG_SAMPLES_PER_FRAME, 16'd4);
    send_sample(32'h0080_0000, 1'b0);
    send_sample(32'h007F_FFFF, 1'b0);
    send_sample(32'hAB80_0001, 1'b1);
    settle();

    // 32-bit extremes into a maximum length frame, then shorten it mid-frame
    set_bytes(16'd4);
    write_reg(CFG_SAMPLES_PER_FRAME, 16'hFFFF);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    settle();
    write_reg(CFG_SAMPLES_PER_FRAME, 16'd2);
    send_sample(32'h0000_0001, 1'b0);
    settle();

    // byte counts above four behave as four
    set_bytes(16'd7);
    write_reg(CFG_SAMPLES_PER_FRAME, 16'd1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    settle();
    set_bytes(16'd5);
    send_sample(32'hDEAD_BEEF, 1'b1);
    settle();

    // random phases, each with fresh settings; the last two run without gaps
    for (int ph = 0; ph < 12; ph++) begin
      data = CFG_DATA_W'($urandom);
      set_bytes(data);
      pick = $urandom_range(0, 9);
      if (pick == 0) data = '0;
      else if (pick == 1) data = CFG_DATA_W'($urandom_range(200, 65535));
      else if (pick == 2) data = 16'hFFFF;
      else data = CFG_DATA_W'($urandom_range(1, 24));
      write_reg(CFG_SAMPLES_PER_FRAME, data);
      calm = (ph >= 10);
      for (int i = 0; i < 86; i++) begin
        send_sample(pick_word(eff_bytes), $urandom_range(0, 11) == 0);
        maybe_pause();
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/pcmamp_pkg.sv
hdl/pcm_sample_decode_frame_amplitude.sv
verif/pcm_amplitude_checker.sv
verif/tb_pcm_sample_decode_frame_amplitude.sv
